FILE: rtl/pdaw_pkg.sv
package pdaw_pkg;

    // default drive ceiling
    localparam int DRIVE_MAX_DEF = 100;

    // field and datapath widths
    localparam int MEAS_W     = 12;
    localparam int TGT_W      = 12;
    localparam int ERR_W      = 13;
    localparam int DELTA_W    = 14;
    localparam int SUM_W      = 18;
    localparam int GAIN_W     = 16;
    localparam int OFF_W      = 7;
    localparam int DRV_W      = 7;
    localparam int NUM_W      = 50;
    localparam int MUL_B_W    = 16;
    localparam int PROD_W     = 66;
    localparam int DEN_W      = 42;
    localparam int DIV_W      = 65;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // gains and times are in thousandths
    localparam logic [MUL_B_W-1:0] K_MILLI = 16'd1000;

    // register reset values
    localparam logic [GAIN_W-1:0] RST_PROP_GAIN  = 16'd1000;
    localparam logic [GAIN_W-1:0] RST_INT_TIME   = 16'd1000;
    localparam logic [GAIN_W-1:0] RST_DER_TIME   = 16'd0;
    localparam logic [TGT_W-1:0]  RST_TARGET     = 12'd0;
    localparam logic [OFF_W-1:0]  RST_OFFSET     = 7'd50;
    localparam logic [GAIN_W-1:0] RST_INT_LIMIT  = 16'd1000;
    localparam logic [GAIN_W-1:0] RST_PERIOD     = 16'd50;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INT_TIME  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DER_TIME  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INT_LIMIT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD    = 3'd6;

    // multiplier operand pairs
    localparam logic [3:0] MUL_NONE      = 4'd0;
    localparam logic [3:0] MUL_ERR_T     = 4'd1;
    localparam logic [3:0] MUL_TMP_KI    = 4'd2;
    localparam logic [3:0] MUL_SUM_T     = 4'd3;
    localparam logic [3:0] MUL_TMP_T     = 4'd4;
    localparam logic [3:0] MUL_DELTA_KD  = 4'd5;
    localparam logic [3:0] MUL_T_KI      = 4'd6;
    localparam logic [3:0] MUL_TMP_MILLI = 4'd7;
    localparam logic [3:0] MUL_TMP_KP    = 4'd8;

    // product writeback targets
    localparam logic [2:0] WB_NONE    = 3'd0;
    localparam logic [2:0] WB_TMP     = 3'd1;
    localparam logic [2:0] WB_NUM_SET = 3'd2;
    localparam logic [2:0] WB_NUM_ADD = 3'd3;
    localparam logic [2:0] WB_DEN     = 3'd4;

    typedef struct packed {
        logic [GAIN_W-1:0] prop_gain_milli;
        logic [GAIN_W-1:0] int_time_milli;
        logic [GAIN_W-1:0] der_time_milli;
        logic [TGT_W-1:0]  target_distance;
        logic [OFF_W-1:0]  drive_offset;
        logic [GAIN_W-1:0] integral_limit;
        logic [GAIN_W-1:0] period_ms;
    } t_cfg;

    typedef struct packed {
        logic       load;
        logic [3:0] mul_op;
        logic [2:0] wb_op;
        logic       mag;
        logic       div_init;
        logic       div_step;
        logic       fin;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_sts;

endpackage

FILE: rtl/pid_drive_with_antiwindup_top.sv
// an accepted item runs through the sequencer to o_out_valid; the block takes no new item until
// the sequencer is back in idle, which is put off while a finished result waits behind a
// stalled output register
// each item takes nine passes through one shared 50x16 multiplier and a restoring divider
// that produces one quotient bit per cycle
// reset (synchronous, active low) restores all registers to their defaults and clears the
// integral sum, the previous error and the output valid
module pid_drive_with_antiwindup_top #(
    parameter int DRIVE_MAX = pdaw_pkg::DRIVE_MAX_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input item channel
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [pdaw_pkg::MEAS_W-1:0]        i_measured_distance,
    // result item channel
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [pdaw_pkg::DRV_W-1:0]         o_drive_value,
    output logic signed [pdaw_pkg::ERR_W-1:0]  o_control_error,
    // register write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [pdaw_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pdaw_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import pdaw_pkg::*;

    t_cfg    cfg;
    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;
    logic    busy;

    // gains, setpoint, offset, clamp and period
    pdaw_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // sequencer: numerator terms, denominator, magnitude, gain product, division, output
    pdaw_ctrl #(
        .DRIVE_MAX (DRIVE_MAX)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_busy     (busy),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    // error, clamped integral, shared multiplier, divider and output register
    pdaw_dp #(
        .DRIVE_MAX (DRIVE_MAX)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg               (cfg),
        .i_cmd               (dp_cmd),
        .o_sts               (dp_sts),
        .i_measured_distance (i_measured_distance),
        .i_out_stall         (i_out_stall),
        .o_out_valid         (o_out_valid),
        .o_drive_value       (o_drive_value),
        .o_control_error     (o_control_error)
    );

    // an item is taken only while the sequencer is idle; the output register lets
    // the next item in while a finished result still waits
    assign o_in_stall = busy;

    // delivered drive never exceeds the ceiling
    a_drive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_drive_value) <= DRIVE_MAX))
        else $error("drive above ceiling");

    // an accepted item starts the sequence
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("sequencer did not start on accepted item");

    // a new result only comes out of a running sequence
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without a computation");

endmodule

FILE: rtl/pdaw_cfg.sv
module pdaw_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [pdaw_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pdaw_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output pdaw_pkg::t_cfg                      o_cfg
);
    import pdaw_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain_milli <= RST_PROP_GAIN;
            r_cfg.int_time_milli  <= RST_INT_TIME;
            r_cfg.der_time_milli  <= RST_DER_TIME;
            r_cfg.target_distance <= RST_TARGET;
            r_cfg.drive_offset    <= RST_OFFSET;
            r_cfg.integral_limit  <= RST_INT_LIMIT;
            r_cfg.period_ms       <= RST_PERIOD;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_PROP_GAIN: r_cfg.prop_gain_milli <= i_cfg_data[GAIN_W-1:0];
                REG_INT_TIME:  r_cfg.int_time_milli  <= i_cfg_data[GAIN_W-1:0];
                REG_DER_TIME:  r_cfg.der_time_milli  <= i_cfg_data[GAIN_W-1:0];
                REG_TARGET:    r_cfg.target_distance <= i_cfg_data[TGT_W-1:0];
                REG_OFFSET:    r_cfg.drive_offset    <= i_cfg_data[OFF_W-1:0];
                REG_INT_LIMIT: r_cfg.integral_limit  <= i_cfg_data[GAIN_W-1:0];
                REG_PERIOD:    r_cfg.period_ms       <= i_cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

FILE: rtl/pdaw_dp.sv
module pdaw_dp #(
    parameter int DRIVE_MAX = pdaw_pkg::DRIVE_MAX_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  pdaw_pkg::t_cfg                     i_cfg,
    input  pdaw_pkg::t_dp_cmd                  i_cmd,
    output pdaw_pkg::t_dp_sts                  o_sts,
    input  logic [pdaw_pkg::MEAS_W-1:0]        i_measured_distance,
    input  logic                               i_out_stall,
    output logic                               o_out_valid,
    output logic [pdaw_pkg::DRV_W-1:0]         o_drive_value,
    output logic signed [pdaw_pkg::ERR_W-1:0]  o_control_error
);
    import pdaw_pkg::*;

    localparam int QUO_W  = $clog2(DRIVE_MAX + 128) + 1;
    localparam int SUMX_W = SUM_W + 1;
    localparam logic [QUO_W:0] DRIVE_MAX_V = (QUO_W + 1)'(DRIVE_MAX);

    logic [GAIN_W-1:0]          period_eff;
    logic [GAIN_W-1:0]          int_time_eff;
    logic signed [ERR_W-1:0]    load_err;
    logic signed [SUMX_W-1:0]   sum_raw;
    logic signed [SUMX_W-1:0]   lim_pos;
    logic signed [SUMX_W-1:0]   lim_neg;
    logic signed [SUM_W-1:0]    sum_clamped;
    logic signed [NUM_W-1:0]    mul_a;
    logic [MUL_B_W-1:0]         mul_b;
    logic signed [PROD_W:0]     mul_full;
    logic [DIV_W-1:0]           den_ext;
    logic [QUO_W:0]             off_ext;
    logic [QUO_W:0]             quo_ext;
    logic [QUO_W:0]             sum_up;
    logic [QUO_W:0]             drive_diff;
    logic [QUO_W:0]             drive_full;

    logic signed [ERR_W-1:0]    r_err;
    logic signed [SUM_W-1:0]    r_sum;
    logic signed [DELTA_W-1:0]  r_delta;
    logic signed [NUM_W-1:0]    r_tmp;
    logic signed [NUM_W-1:0]    r_num;
    logic signed [PROD_W-1:0]   r_prod;
    logic [DEN_W-1:0]           r_den;
    logic [DIV_W-1:0]           r_rem;
    logic [DIV_W-1:0]           r_dsr;
    logic [QUO_W-1:0]           r_quo;
    logic                       r_qsat;
    logic                       r_num_le0;
    logic                       r_out_valid;
    logic [DRV_W-1:0]           r_drive;
    logic signed [ERR_W-1:0]    r_error;

    // zero time constants count as one
    assign period_eff   = (i_cfg.period_ms == '0) ? GAIN_W'(1) : i_cfg.period_ms;
    assign int_time_eff = (i_cfg.int_time_milli == '0) ? GAIN_W'(1) : i_cfg.int_time_milli;

    // error and clamped integral for the incoming item
    assign load_err = $signed({1'b0, i_cfg.target_distance})
                    - $signed({1'b0, i_measured_distance});
    assign sum_raw  = SUMX_W'(r_sum) + SUMX_W'(load_err);
    assign lim_pos  = SUMX_W'($signed({1'b0, i_cfg.integral_limit}));
    assign lim_neg  = -lim_pos;

    always_comb begin
        if (sum_raw > lim_pos) begin
            sum_clamped = lim_pos[SUM_W-1:0];
        end else if (sum_raw < lim_neg) begin
            sum_clamped = lim_neg[SUM_W-1:0];
        end else begin
            sum_clamped = sum_raw[SUM_W-1:0];
        end
    end

    // shared multiplier operand select
    always_comb begin
        unique case (i_cmd.mul_op)
            MUL_ERR_T: begin
                mul_a = NUM_W'(r_err);
                mul_b = period_eff;
            end
            MUL_TMP_KI: begin
                mul_a = r_tmp;
                mul_b = int_time_eff;
            end
            MUL_SUM_T: begin
                mul_a = NUM_W'(r_sum);
                mul_b = period_eff;
            end
            MUL_TMP_T: begin
                mul_a = r_tmp;
                mul_b = period_eff;
            end
            MUL_DELTA_KD: begin
                mul_a = NUM_W'(r_delta);
                mul_b = i_cfg.der_time_milli;
            end
            MUL_T_KI: begin
                mul_a = NUM_W'($signed({1'b0, period_eff}));
                mul_b = int_time_eff;
            end
            MUL_TMP_MILLI: begin
                mul_a = r_tmp;
                mul_b = K_MILLI;
            end
            MUL_TMP_KP: begin
                mul_a = r_tmp;
                mul_b = i_cfg.prop_gain_milli;
            end
            default: begin
                mul_a = r_tmp;
                mul_b = '0;
            end
        endcase
    end

    assign mul_full = mul_a * $signed({1'b0, mul_b});
    assign den_ext  = DIV_W'(r_den);

    // final drive from quotient, remainder and sign of the numerator
    assign off_ext    = (QUO_W + 1)'(i_cfg.drive_offset);
    assign quo_ext    = {1'b0, r_quo};
    assign sum_up     = off_ext + quo_ext;
    assign drive_diff = off_ext - quo_ext - (QUO_W + 1)'(|r_rem);

    always_comb begin
        if (r_num_le0) begin
            drive_full = (r_qsat || sum_up > DRIVE_MAX_V) ? DRIVE_MAX_V : sum_up;
        end else if (r_qsat || quo_ext >= off_ext) begin
            drive_full = '0;
        end else begin
            // an offset above the ceiling still leaves the drive at the ceiling
            drive_full = (drive_diff > DRIVE_MAX_V) ? DRIVE_MAX_V : drive_diff;
        end
    end

    // integral and error state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err <= '0;
            r_sum <= '0;
        end else if (i_cmd.load) begin
            r_err <= load_err;
            r_sum <= sum_clamped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_delta <= DELTA_W'(r_err) - DELTA_W'(load_err);
        end
        if (i_cmd.mul_op != MUL_NONE) begin
            r_prod <= mul_full[PROD_W-1:0];
        end
        unique case (i_cmd.wb_op)
            WB_TMP:     r_tmp <= r_prod[NUM_W-1:0];
            WB_NUM_SET: r_num <= r_prod[NUM_W-1:0];
            WB_NUM_ADD: r_num <= r_num + r_prod[NUM_W-1:0];
            WB_DEN:     r_den <= r_prod[DEN_W-1:0];
            default: ;
        endcase
        if (i_cmd.mag) begin
            r_num_le0 <= r_num[NUM_W-1] || (r_num == '0);
            r_tmp     <= r_num[NUM_W-1] ? -r_num : r_num;
        end
        // restoring division, one quotient bit per step
        if (i_cmd.div_init) begin
            r_rem  <= r_prod[DIV_W-1:0];
            r_dsr  <= den_ext << (QUO_W - 1);
            r_qsat <= r_prod[DIV_W-1:0] >= (den_ext << QUO_W);
            r_quo  <= '0;
        end else if (i_cmd.div_step) begin
            if (r_rem >= r_dsr) begin
                r_rem <= r_rem - r_dsr;
                r_quo <= {r_quo[QUO_W-2:0], 1'b1};
            end else begin
                r_quo <= {r_quo[QUO_W-2:0], 1'b0};
            end
            r_dsr <= r_dsr >> 1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.fin) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_drive <= drive_full[DRV_W-1:0];
            r_error <= r_err;
        end
    end

    assign o_sts.out_free   = !r_out_valid || !i_out_stall;
    assign o_out_valid      = r_out_valid;
    assign o_drive_value    = r_drive;
    assign o_control_error  = r_error;

endmodule

FILE: rtl/pdaw_ctrl.sv
module pdaw_ctrl #(
    parameter int DRIVE_MAX = pdaw_pkg::DRIVE_MAX_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_busy,
    input  pdaw_pkg::t_dp_sts  i_sts,
    output pdaw_pkg::t_dp_cmd  o_cmd
);
    import pdaw_pkg::*;

    localparam int QUO_W = $clog2(DRIVE_MAX + 128) + 1;
    localparam int CNT_W = $clog2(QUO_W);

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_M1       = 5'd1;
    localparam logic [4:0] S_W1       = 5'd2;
    localparam logic [4:0] S_M2       = 5'd3;
    localparam logic [4:0] S_W2       = 5'd4;
    localparam logic [4:0] S_M3       = 5'd5;
    localparam logic [4:0] S_W3       = 5'd6;
    localparam logic [4:0] S_M4       = 5'd7;
    localparam logic [4:0] S_W4       = 5'd8;
    localparam logic [4:0] S_M5       = 5'd9;
    localparam logic [4:0] S_W5       = 5'd10;
    localparam logic [4:0] S_M6       = 5'd11;
    localparam logic [4:0] S_W6       = 5'd12;
    localparam logic [4:0] S_M7       = 5'd13;
    localparam logic [4:0] S_W7       = 5'd14;
    localparam logic [4:0] S_M8       = 5'd15;
    localparam logic [4:0] S_W8       = 5'd16;
    localparam logic [4:0] S_MAG      = 5'd17;
    localparam logic [4:0] S_M9       = 5'd18;
    localparam logic [4:0] S_DIV_INIT = 5'd19;
    localparam logic [4:0] S_DIV      = 5'd20;
    localparam logic [4:0] S_FIN      = 5'd21;

    logic [4:0]       r_state;
    logic [4:0]       n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_M1;
                end
            end
            // e*T*Ki
            S_M1: begin o_cmd.mul_op = MUL_ERR_T;     n_state = S_W1; end
            S_W1: begin o_cmd.wb_op  = WB_TMP;        n_state = S_M2; end
            S_M2: begin o_cmd.mul_op = MUL_TMP_KI;    n_state = S_W2; end
            S_W2: begin o_cmd.wb_op  = WB_NUM_SET;    n_state = S_M3; end
            // sum*T*T
            S_M3: begin o_cmd.mul_op = MUL_SUM_T;     n_state = S_W3; end
            S_W3: begin o_cmd.wb_op  = WB_TMP;        n_state = S_M4; end
            S_M4: begin o_cmd.mul_op = MUL_TMP_T;     n_state = S_W4; end
            S_W4: begin o_cmd.wb_op  = WB_NUM_ADD;    n_state = S_M5; end
            // Kd*delta*Ki
            S_M5: begin o_cmd.mul_op = MUL_DELTA_KD;  n_state = S_W5; end
            S_W5: begin o_cmd.wb_op  = WB_TMP;        n_state = S_M6; end
            S_M6: begin o_cmd.mul_op = MUL_TMP_KI;    n_state = S_W6; end
            S_W6: begin o_cmd.wb_op  = WB_NUM_ADD;    n_state = S_M7; end
            // denominator 1000*T*Ki
            S_M7: begin o_cmd.mul_op = MUL_T_KI;      n_state = S_W7; end
            S_W7: begin o_cmd.wb_op  = WB_TMP;        n_state = S_M8; end
            S_M8: begin o_cmd.mul_op = MUL_TMP_MILLI; n_state = S_W8; end
            S_W8: begin o_cmd.wb_op  = WB_DEN;        n_state = S_MAG; end
            S_MAG: begin o_cmd.mag   = 1'b1;          n_state = S_M9; end
            S_M9: begin o_cmd.mul_op = MUL_TMP_KP;    n_state = S_DIV_INIT; end
            S_DIV_INIT: begin
                o_cmd.div_init = 1'b1;
                n_cnt          = CNT_W'(QUO_W - 1);
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_FIN;
                end else begin
                    n_cnt = r_cnt - CNT_W'(1);
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

FILE: tb/sv/testbench.sv
module testbench;
    import pdaw_pkg::*;

    // clock, run limits and settle times
    localparam int HALF_PERIOD   = 6;
    localparam int SETTLE_CYCLES = 40;      // comfortably past the time one item takes
    localparam int DRAIN_LIMIT   = 4000;
    localparam int RUN_LIMIT     = 8000000;
    localparam int RAND_PHASES   = 10;
    localparam int PHASE_ITEMS   = 110;
    localparam int MAX_REPORTS   = 10;
    localparam longint MILLI     = 1000;

    // write index past the last register, must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

    typedef struct {
        logic [MEAS_W-1:0]        distance;
        logic [DRV_W-1:0]         drive;
        logic signed [ERR_W-1:0]  error;
    } drive_result_t;

    // drive predictor plus the queue of drive results still owed by the block
    class pid_drive_model;
        logic [GAIN_W-1:0]        kp_milli;
        logic [GAIN_W-1:0]        int_time;
        logic [GAIN_W-1:0]        der_time;
        logic [TGT_W-1:0]         target;
        logic [OFF_W-1:0]         offset;
        logic [GAIN_W-1:0]        int_limit;
        logic [GAIN_W-1:0]        period;
        logic signed [SUM_W-1:0]  integ;
        logic signed [ERR_W-1:0]  prev_err;
        drive_result_t            pending_drives[$];
        int                       mismatches;
        int                       checked;
        int                       at_floor;
        int                       at_ceiling;

        function new();
            kp_milli   = RST_PROP_GAIN;
            int_time   = RST_INT_TIME;
            der_time   = RST_DER_TIME;
            target     = RST_TARGET;
            offset     = RST_OFFSET;
            int_limit  = RST_INT_LIMIT;
            period     = RST_PERIOD;
            integ      = '0;
            prev_err   = '0;
            mismatches = 0;
            checked    = 0;
            at_floor   = 0;
            at_ceiling = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_PROP_GAIN: kp_milli  = data;
                REG_INT_TIME:  int_time  = data;
                REG_DER_TIME:  der_time  = data;
                REG_TARGET:    target    = data[TGT_W-1:0];
                REG_OFFSET:    offset    = data[OFF_W-1:0];
                REG_INT_LIMIT: int_limit = data;
                REG_PERIOD:    period    = data;
                default: ;
            endcase
        endfunction

        function void note_distance(logic [MEAS_W-1:0] meas);
            longint        err, sum, lim, delta, t, ki, kd, num;
            longint unsigned mag, den, kp, q1, r1, prod, quo, rem, off, drv;
            drive_result_t res;
            err   = longint'(target) - longint'(meas);
            lim   = longint'(int_limit);
            sum   = longint'(integ) + err;
            if (sum > lim) sum = lim;
            if (sum < -lim) sum = -lim;
            delta = longint'(prev_err) - err;
            // zero time settings count as one
            t     = (period == '0) ? 1 : longint'(period);
            ki    = (int_time == '0) ? 1 : longint'(int_time);
            kd    = longint'(der_time);
            num   = err * t * ki + sum * t * t + delta * kd * ki;
            mag   = (num < 0) ? -num : num;
            den   = MILLI * t * ki;
            kp    = kp_milli;
            // split the division so kp*mag never overflows
            q1    = mag / den;
            r1    = mag % den;
            prod  = kp * r1;
            quo   = kp * q1 + prod / den;
            rem   = prod % den;
            off   = offset;
            if (num <= 0) begin
                drv = off + quo;
            end else if (quo >= off) begin
                drv = 0;
            end else begin
                drv = off - quo;
                if (rem != 0) drv -= 1;
            end
            if (drv > DRIVE_MAX_DEF) drv = DRIVE_MAX_DEF;
            if (drv == 0) at_floor++;
            if (drv == DRIVE_MAX_DEF) at_ceiling++;
            integ    = sum[SUM_W-1:0];
            prev_err = err[ERR_W-1:0];
            res.distance = meas;
            res.drive    = drv[DRV_W-1:0];
            res.error    = err[ERR_W-1:0];
            pending_drives.push_back(res);
        endfunction

        function void note_mismatch(string msg);
            mismatches++;
            if (mismatches <= MAX_REPORTS) $display("mismatch: %s", msg);
        endfunction

        function void check_result(logic [DRV_W-1:0] drv, logic signed [ERR_W-1:0] err);
            drive_result_t exp_res;
            checked++;
            if (pending_drives.size() == 0) begin
                note_mismatch($sformatf("unexpected result drive %0d error %0d", drv, err));
                return;
            end
            exp_res = pending_drives.pop_front();
            if (drv !== exp_res.drive || err !== exp_res.error)
                note_mismatch($sformatf("distance %0d: drive exp %0d got %0d, error exp %0d got %0d",
                                        exp_res.distance, exp_res.drive, drv, exp_res.error, err));
        endfunction
    endclass

    // dut connections
    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_stall;
    logic [MEAS_W-1:0]        i_measured_distance;
    logic                     o_out_valid;
    logic                     i_out_stall;
    logic [DRV_W-1:0]         o_drive_value;
    logic signed [ERR_W-1:0]  o_control_error;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [CFG_IDX_W-1:0]     i_cfg_index;
    logic [CFG_DATA_W-1:0]    i_cfg_data;

    pid_drive_model dist_model;
    bit             no_idle;
    int             items_sent;
    int             settings_count;

    pid_drive_with_antiwindup_top u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_measured_distance (i_measured_distance),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_drive_value       (o_drive_value),
        .o_control_error     (o_control_error),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #HALF_PERIOD;
        i_clk = 1'b1;
        #HALF_PERIOD;
    end

    // idle cycles before an item, none during quiet phases
    function automatic int idle_draw();
        return no_idle ? 0 : $urandom_range(0, 8);
    endfunction

    // register value biased toward the ends of the range
    function automatic logic [CFG_DATA_W-1:0] edgy16();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return 16'd1;
            default: return 16'($urandom());
        endcase
    endfunction

    // random register value, wild phases roam the full range
    function automatic logic [CFG_DATA_W-1:0] setting_value(logic [CFG_IDX_W-1:0] idx, bit wild);
        logic [CFG_DATA_W-1:0] junk;
        junk = 16'($urandom());
        if (wild) return edgy16();
        case (idx)
            REG_PROP_GAIN: return 16'($urandom_range(0, 4000));
            REG_INT_TIME:  return 16'($urandom_range(50, 5000));
            REG_DER_TIME:  return 16'($urandom_range(0, 1000));
            // upper bits are junk that the register drops
            REG_TARGET:    return {junk[15:12], 12'($urandom_range(0, 4095))};
            REG_OFFSET:    return {junk[15:7], 7'($urandom_range(0, 100))};
            REG_INT_LIMIT: return 16'($urandom_range(0, 20000));
            REG_PERIOD:    return 16'($urandom_range(1, 200));
            default:       return junk;
        endcase
    endfunction

    // one register write on the config channel
    task automatic load_register(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        dist_model.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic apply_settings(input logic [CFG_DATA_W-1:0] kp, ki, kd, tgt, off, lim, per);
        load_register(REG_PROP_GAIN, kp);
        load_register(REG_INT_TIME, ki);
        load_register(REG_DER_TIME, kd);
        load_register(REG_TARGET, tgt);
        load_register(REG_OFFSET, off);
        load_register(REG_INT_LIMIT, lim);
        load_register(REG_PERIOD, per);
        settings_count++;
    endtask

    // one distance item; valid stays up when the next item follows with no gap
    task automatic send_distance(input logic [MEAS_W-1:0] meas_mm);
        int gap;
        gap = idle_draw();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid          <= 1'b1;
        i_measured_distance <= meas_mm;
        do @(posedge i_clk); while (o_in_stall);
        dist_model.note_distance(meas_mm);
        items_sent++;
    endtask

    // drop valid, let every owed result come back, then let the block go idle
    task automatic settle();
        int guard;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        guard = 0;
        while (dist_model.pending_drives.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // result side: stall is held across the arrival of valid for the drawn count
    initial begin
        int n;
        i_out_stall = 1'b0;
        forever begin
            n = idle_draw();
            @(negedge i_clk);
            if (n > 0) begin
                i_out_stall <= 1'b1;
                do @(posedge i_clk); while (!o_out_valid);
                repeat (n) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            dist_model.check_result(o_drive_value, o_control_error);
        end
    end

    // hard stop in case the block hangs
    initial begin
        #RUN_LIMIT;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        logic [MEAS_W-1:0] dir_defaults [6] = '{12'd0, 12'd4095, 12'd4095, 12'hAAA, 12'h555, 12'd1};
        logic [MEAS_W-1:0] dir_extreme  [5] = '{12'd0, 12'd4095, 12'd0, 12'd4095, 12'd2048};
        logic [MEAS_W-1:0] dir_slow     [8] = '{12'd0, 12'd0, 12'd0, 12'd4095, 12'd4095,
                                                12'd4095, 12'd2048, 12'd4094};
        logic [MEAS_W-1:0] dir_tuned    [5] = '{12'd1990, 12'd2010, 12'd2000, 12'd1500, 12'd2500};
        int                d;
        int                failures;
        bit                wild;

        dist_model          = new();
        no_idle             = 1'b0;
        items_sent          = 0;
        settings_count      = 1;
        i_rst_n             = 1'b0;
        i_in_valid          = 1'b0;
        i_measured_distance = '0;
        i_cfg_valid         = 1'b0;
        i_cfg_index         = REG_PROP_GAIN;
        i_cfg_data          = '0;

        // hold the synchronous reset, then release it
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings, integral runs into the negative clamp
        foreach (dir_defaults[k]) send_distance(dir_defaults[k]);
        settle();

        // top gains, zero time registers, zero clamp, oversized target and offset
        apply_settings(16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0);
        load_register(REG_UNMAPPED, 16'($urandom()));
        foreach (dir_extreme[k]) send_distance(dir_extreme[k]);
        settle();

        // no proportional gain, longest times, integral hits the positive clamp
        apply_settings(16'd0, 16'hFFFF, 16'd0, 16'd4095, 16'd100, 16'd5000, 16'hFFFF);
        foreach (dir_slow[k]) send_distance(dir_slow[k]);
        settle();

        // moderate tuning so the drive sits between the rails
        apply_settings(16'd1000, 16'd1000, 16'd500, 16'd2000, 16'd50, 16'hFFFF, 16'd20);
        foreach (dir_tuned[k]) send_distance(dir_tuned[k]);
        settle();

        // random phases, alternating tame and wild settings
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            wild    = ph[0];
            no_idle = ($urandom_range(0, 3) == 0);
            for (int r = REG_PROP_GAIN; r <= REG_UNMAPPED; r++)
                if ($urandom_range(0, 1)) load_register(r[CFG_IDX_W-1:0],
                                                        setting_value(r[CFG_IDX_W-1:0], wild));
            settings_count++;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(0, 4) < 3) begin
                    // close to the setpoint, keeps the loop out of saturation
                    d = int'(dist_model.target) + int'($urandom_range(0, 128)) - 64;
                    if (d < 0) d = 0;
                    if (d > 4095) d = 4095;
                end else begin
                    d = $urandom_range(0, 4095);
                end
                send_distance(d[MEAS_W-1:0]);
            end
            settle();
        end

        failures = dist_model.mismatches + dist_model.pending_drives.size();
        if (dist_model.pending_drives.size() != 0)
            $display("%0d drive results never arrived", dist_model.pending_drives.size());
        $display("checked %0d drive results from %0d distance items over %0d register settings",
                 dist_model.checked, items_sent, settings_count);
        $display("drive predicted at zero %0d times and at the ceiling %0d times",
                 dist_model.at_floor, dist_model.at_ceiling);
        if (failures == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
